>>> design/dpec_pkg.sv
package dpec_pkg;
  localparam int VALUE_WIDTH_DEF = 24;
  localparam int CD_WIDTH = 23;
  localparam logic [CD_WIDTH-1:0] CD_RESET = 23'd2560;
endpackage

>>> design/dpec_front.sv
module dpec_front
  import dpec_pkg::*;
#(
  parameter int VW = VALUE_WIDTH_DEF,
  parameter int MW = VW + 1,
  parameter int D2W = 2 * MW + 1,
  parameter int NW = 3 * MW + 1,
  parameter int TW = 4 * VW + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [VW-1:0] a_pos_x,
  input  logic signed [VW-1:0] a_pos_y,
  input  logic signed [VW-1:0] a_vel_x,
  input  logic signed [VW-1:0] a_vel_y,
  input  logic signed [VW-1:0] b_pos_x,
  input  logic signed [VW-1:0] b_pos_y,
  input  logic signed [VW-1:0] b_vel_x,
  input  logic signed [VW-1:0] b_vel_y,
  input  logic [CD_WIDTH-1:0]  contact_distance,
  output logic                 f_valid,
  output logic [NW-1:0]        n_x,
  output logic [NW-1:0]        n_y,
  output logic [D2W-1:0]       d2_out,
  output logic [TW-1:0]        tag
);
  localparam int FW = 2 * MW + 1;
  localparam int HL = (FW + 1) / 2;
  localparam int HH = FW - HL;
  localparam int VT = 4 * VW;
  localparam int LW = (D2W > 2 * CD_WIDTH) ? D2W : 2 * CD_WIDTH;

  logic v1, v2, v3, v4, v5;

  // stage 1: differences
  logic signed [VW:0] s1_dx, s1_dy, s1_dvx, s1_dvy;
  logic [VT-1:0]      s1_vel;
  logic [CD_WIDTH-1:0] s1_cd;

  // stage 2: magnitudes and products
  logic [MW-1:0]      s2_mx, s2_my;
  logic [D2W-1:0]     s2_d2;
  logic [2*CD_WIDTH-1:0] s2_lim;
  logic [2*MW-1:0]    s2_p1, s2_p2;
  logic               s2_n1, s2_n2, s2_sx, s2_sy;
  logic [VT-1:0]      s2_vel;

  // stage 3: contact test and dot product
  logic [MW-1:0]      s3_mx, s3_my;
  logic [D2W-1:0]     s3_d2;
  logic [FW-1:0]      s3_fm;
  logic               s3_contact, s3_apply, s3_negx, s3_negy;
  logic [VT-1:0]      s3_vel;

  // stage 4: partial products
  logic [MW+HL-1:0]   s4_xl, s4_yl;
  logic [MW+HH-1:0]   s4_xh, s4_yh;
  logic [D2W-1:0]     s4_d2;
  logic [3:0]         s4_flags;
  logic [VT-1:0]      s4_vel;

  logic [MW-1:0]      mx_c, my_c, mdvx_c, mdvy_c;
  logic [FW-1:0]      fm_c;
  logic               fneg_c;

  always_comb begin
    mx_c = s1_dx[VW] ? MW'(-s1_dx) : MW'(s1_dx);
    my_c = s1_dy[VW] ? MW'(-s1_dy) : MW'(s1_dy);
    mdvx_c = s1_dvx[VW] ? MW'(-s1_dvx) : MW'(s1_dvx);
    mdvy_c = s1_dvy[VW] ? MW'(-s1_dvy) : MW'(s1_dvy);
  end

  always_comb begin
    if (s2_n1 == s2_n2) begin
      fm_c = FW'(s2_p1) + FW'(s2_p2);
      fneg_c = s2_n1;
    end else if (s2_p1 >= s2_p2) begin
      fm_c = FW'(s2_p1 - s2_p2);
      fneg_c = s2_n1;
    end else begin
      fm_c = FW'(s2_p2 - s2_p1);
      fneg_c = s2_n2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx  <= (VW+1)'(a_pos_x) - (VW+1)'(b_pos_x);
      s1_dy  <= (VW+1)'(a_pos_y) - (VW+1)'(b_pos_y);
      s1_dvx <= (VW+1)'(a_vel_x) - (VW+1)'(b_vel_x);
      s1_dvy <= (VW+1)'(a_vel_y) - (VW+1)'(b_vel_y);
      s1_vel <= {a_vel_x, a_vel_y, b_vel_x, b_vel_y};
      s1_cd  <= contact_distance;

      s2_mx  <= mx_c;
      s2_my  <= my_c;
      s2_d2  <= D2W'(mx_c * mx_c) + D2W'(my_c * my_c);
      s2_lim <= s1_cd * s1_cd;
      s2_p1  <= mdvx_c * mx_c;
      s2_p2  <= mdvy_c * my_c;
      s2_n1  <= s1_dvx[VW] != s1_dx[VW];
      s2_n2  <= s1_dvy[VW] != s1_dy[VW];
      s2_sx  <= s1_dx[VW];
      s2_sy  <= s1_dy[VW];
      s2_vel <= s1_vel;

      s3_mx  <= s2_mx;
      s3_my  <= s2_my;
      s3_d2  <= s2_d2;
      s3_fm  <= fm_c;
      s3_contact <= LW'(s2_d2) <= LW'(s2_lim);
      s3_apply <= (LW'(s2_d2) <= LW'(s2_lim)) && (s2_d2 != '0);
      s3_negx <= s2_sx != fneg_c;
      s3_negy <= s2_sy != fneg_c;
      s3_vel <= s2_vel;

      s4_xl <= s3_mx * s3_fm[HL-1:0];
      s4_xh <= s3_mx * s3_fm[FW-1:HL];
      s4_yl <= s3_my * s3_fm[HL-1:0];
      s4_yh <= s3_my * s3_fm[FW-1:HL];
      s4_d2 <= s3_d2;
      s4_flags <= {s3_contact, s3_apply, s3_negx, s3_negy};
      s4_vel <= s3_vel;

      n_x <= NW'(s4_xl) + (NW'(s4_xh) << HL);
      n_y <= NW'(s4_yl) + (NW'(s4_yh) << HL);
      d2_out <= s4_d2;
      tag <= {s4_vel, s4_flags};
    end
  end

  assign f_valid = v5;
endmodule

>>> design/dpec_div.sv
module dpec_div
  import dpec_pkg::*;
#(
  parameter int VW = VALUE_WIDTH_DEF,
  parameter int MW = VW + 1,
  parameter int D2W = 2 * MW + 1,
  parameter int NW = 3 * MW + 1,
  parameter int QW = VW + 1,
  parameter int TW = 4 * VW + 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           d_valid,
  input  logic [NW-1:0]  n_x,
  input  logic [NW-1:0]  n_y,
  input  logic [D2W-1:0] den,
  input  logic [TW-1:0]  tag_in,
  output logic           q_valid,
  output logic [QW-1:0]  q_x,
  output logic [QW-1:0]  q_y,
  output logic [TW-1:0]  tag_out
);
  localparam int RW = NW - QW;

  logic [RW-1:0]  rx [0:QW];
  logic [RW-1:0]  ry [0:QW];
  logic [QW-1:0]  lx [0:QW];
  logic [QW-1:0]  ly [0:QW];
  logic [QW-1:0]  qx [0:QW];
  logic [QW-1:0]  qy [0:QW];
  logic [D2W-1:0] dd [0:QW];
  logic [TW-1:0]  tg [0:QW];
  logic           vv [0:QW];

  assign rx[0] = n_x[NW-1:QW];
  assign ry[0] = n_y[NW-1:QW];
  assign lx[0] = n_x[QW-1:0];
  assign ly[0] = n_y[QW-1:0];
  assign qx[0] = '0;
  assign qy[0] = '0;
  assign dd[0] = den;
  assign tg[0] = tag_in;
  assign vv[0] = d_valid;

  for (genvar j = 1; j <= QW; j++) begin : g_step
    logic [RW:0] tx, ty;
    logic        gx, gy;

    always_comb begin
      tx = {rx[j-1], lx[j-1][QW-1]};
      ty = {ry[j-1], ly[j-1][QW-1]};
      gx = tx >= (RW+1)'(dd[j-1]);
      gy = ty >= (RW+1)'(dd[j-1]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[j] <= 1'b0;
      end else if (en) begin
        vv[j] <= vv[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx[j] <= gx ? RW'(tx - (RW+1)'(dd[j-1])) : RW'(tx);
        ry[j] <= gy ? RW'(ty - (RW+1)'(dd[j-1])) : RW'(ty);
        lx[j] <= lx[j-1] << 1;
        ly[j] <= ly[j-1] << 1;
        qx[j] <= {qx[j-1][QW-2:0], gx};
        qy[j] <= {qy[j-1][QW-2:0], gy};
        dd[j] <= dd[j-1];
        tg[j] <= tg[j-1];
      end
    end
  end

  assign q_valid = vv[QW];
  assign q_x = qx[QW];
  assign q_y = qy[QW];
  assign tag_out = tg[QW];
endmodule

>>> design/dpec_back.sv
module dpec_back
  import dpec_pkg::*;
#(
  parameter int VW = VALUE_WIDTH_DEF,
  parameter int QW = VW + 1,
  parameter int TW = 4 * VW + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 q_valid,
  input  logic [QW-1:0]        q_x,
  input  logic [QW-1:0]        q_y,
  input  logic [TW-1:0]        tag,
  output logic                 out_valid,
  output logic                 in_contact,
  output logic signed [VW-1:0] a_new_vel_x,
  output logic signed [VW-1:0] a_new_vel_y,
  output logic signed [VW-1:0] b_new_vel_x,
  output logic signed [VW-1:0] b_new_vel_y
);
  localparam int EW = VW + 3;
  localparam logic signed [EW-1:0] HI = EW'((64'd1 << (VW - 1)) - 64'd1);
  localparam logic signed [EW-1:0] LO = -HI - EW'(1);

  logic signed [VW-1:0] avx, avy, bvx, bvy;
  logic                 contact, apply, negx, negy;
  logic signed [EW-1:0] sqx, sqy, nax, nay, nbx, nby;

  function automatic logic signed [VW-1:0] clip(input logic signed [EW-1:0] v);
    if (v > HI) clip = HI[VW-1:0];
    else if (v < LO) clip = LO[VW-1:0];
    else clip = v[VW-1:0];
  endfunction

  always_comb begin
    {avx, avy, bvx, bvy, contact, apply, negx, negy} = tag;
    sqx = negx ? -$signed(EW'(q_x)) : $signed(EW'(q_x));
    sqy = negy ? -$signed(EW'(q_y)) : $signed(EW'(q_y));
    if (!apply) begin
      sqx = '0;
      sqy = '0;
    end
    nax = EW'(avx) - sqx;
    nay = EW'(avy) - sqy;
    nbx = EW'(bvx) + sqx;
    nby = EW'(bvy) + sqy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_contact  <= contact;
      a_new_vel_x <= clip(nax);
      a_new_vel_y <= clip(nay);
      b_new_vel_x <= clip(nbx);
      b_new_vel_y <= clip(nby);
    end
  end
endmodule

>>> design/disk_pair_elastic_collision_top.sv
// pipeline: five front stages, one restoring divider stage per quotient bit,
// one output register
// throughput: one item per cycle; a stall on a valid output freezes the whole pipeline
// reset: rst synchronous, clears all valid bits, contact_distance returns to 2560
module disk_pair_elastic_collision_top
  import dpec_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] a_pos_x,
  input  logic signed [VALUE_WIDTH-1:0] a_pos_y,
  input  logic signed [VALUE_WIDTH-1:0] a_vel_x,
  input  logic signed [VALUE_WIDTH-1:0] a_vel_y,
  input  logic signed [VALUE_WIDTH-1:0] b_pos_x,
  input  logic signed [VALUE_WIDTH-1:0] b_pos_y,
  input  logic signed [VALUE_WIDTH-1:0] b_vel_x,
  input  logic signed [VALUE_WIDTH-1:0] b_vel_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          in_contact,
  output logic signed [VALUE_WIDTH-1:0] a_new_vel_x,
  output logic signed [VALUE_WIDTH-1:0] a_new_vel_y,
  output logic signed [VALUE_WIDTH-1:0] b_new_vel_x,
  output logic signed [VALUE_WIDTH-1:0] b_new_vel_y,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CD_WIDTH-1:0]           cfg_data
);
  localparam int MW = VALUE_WIDTH + 1;
  localparam int D2W = 2 * MW + 1;
  localparam int NW = 3 * MW + 1;
  localparam int QW = VALUE_WIDTH + 1;
  localparam int TW = 4 * VALUE_WIDTH + 4;

  logic [CD_WIDTH-1:0] contact_distance;
  logic                en;
  logic                f_valid, q_valid;
  logic [NW-1:0]       n_x, n_y;
  logic [D2W-1:0]      d2;
  logic [TW-1:0]       tag_f, tag_q;
  logic [QW-1:0]       q_x, q_y;

  assign cfg_ready = 1'b1;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      contact_distance <= CD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      contact_distance <= cfg_data;
    end
  end

  dpec_front #(.VW(VALUE_WIDTH), .MW(MW), .D2W(D2W), .NW(NW), .TW(TW)) u_front (
    .clk, .rst, .en, .in_valid,
    .a_pos_x, .a_pos_y, .a_vel_x, .a_vel_y,
    .b_pos_x, .b_pos_y, .b_vel_x, .b_vel_y,
    .contact_distance,
    .f_valid, .n_x, .n_y, .d2_out(d2), .tag(tag_f)
  );

  dpec_div #(.VW(VALUE_WIDTH), .MW(MW), .D2W(D2W), .NW(NW), .QW(QW), .TW(TW)) u_div (
    .clk, .rst, .en, .d_valid(f_valid), .n_x, .n_y, .den(d2), .tag_in(tag_f),
    .q_valid, .q_x, .q_y, .tag_out(tag_q)
  );

  dpec_back #(.VW(VALUE_WIDTH), .QW(QW), .TW(TW)) u_back (
    .clk, .rst, .en, .q_valid, .q_x, .q_y, .tag(tag_q),
    .out_valid, .in_contact, .a_new_vel_x, .a_new_vel_y, .b_new_vel_x, .b_new_vel_y
  );
endmodule

>>> dv/tb.sv
module tb;
  import dpec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = VALUE_WIDTH_DEF;
  localparam int LATENCY = W + 7;
  localparam int NUM_RANDOM = 1730;

  typedef logic signed [W-1:0] val_t;

  typedef struct packed {
    val_t apx, apy, avx, avy, bpx, bpy, bvx, bvy;
  } pair_t;

  typedef struct packed {
    logic contact;
    val_t nax, nay, nbx, nby;
  } bounce_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  val_t a_pos_x = '0, a_pos_y = '0, a_vel_x = '0, a_vel_y = '0;
  val_t b_pos_x = '0, b_pos_y = '0, b_vel_x = '0, b_vel_y = '0;
  logic out_valid;
  logic out_stall = 0;
  logic in_contact;
  val_t a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CD_WIDTH-1:0] cfg_data = '0;

  disk_pair_elastic_collision_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_pos_x(a_pos_x), .a_pos_y(a_pos_y), .a_vel_x(a_vel_x), .a_vel_y(a_vel_y),
    .b_pos_x(b_pos_x), .b_pos_y(b_pos_y), .b_vel_x(b_vel_x), .b_vel_y(b_vel_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .in_contact(in_contact),
    .a_new_vel_x(a_new_vel_x), .a_new_vel_y(a_new_vel_y),
    .b_new_vel_x(b_new_vel_x), .b_new_vel_y(b_new_vel_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  pair_t pending_pairs[$];
  bounce_t expected_bounces[$];
  logic [CD_WIDTH-1:0] contact_dist = CD_RESET;
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int contacts = 0;
  bit hold_off_req = 0;
  int hold_off_left = 0;
  bit sender_pause = 0;

  function automatic val_t saturate(logic signed [63:0] v);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[W-1:0];
    if (v < lo) return lo[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic bounce_t predict_bounce(pair_t p, logic [CD_WIDTH-1:0] cd);
    bounce_t r;
    logic signed [63:0] dx, dy, dvx, dvy, qx, qy;
    logic signed [159:0] d2, f, lim;
    dx = 64'(p.apx) - 64'(p.bpx);
    dy = 64'(p.apy) - 64'(p.bpy);
    dvx = 64'(p.avx) - 64'(p.bvx);
    dvy = 64'(p.avy) - 64'(p.bvy);
    d2 = 160'(dx) * 160'(dx) + 160'(dy) * 160'(dy);
    lim = 160'(cd) * 160'(cd);
    r.contact = d2 <= lim;
    qx = 0;
    qy = 0;
    if (r.contact && d2 != 0) begin
      f = 160'(dvx) * 160'(dx) + 160'(dvy) * 160'(dy);
      qx = 64'((160'(dx) * f) / d2);
      qy = 64'((160'(dy) * f) / d2);
    end
    r.nax = saturate(64'(p.avx) - qx);
    r.nay = saturate(64'(p.avy) - qy);
    r.nbx = saturate(64'(p.bvx) + qx);
    r.nby = saturate(64'(p.bvy) + qy);
    return r;
  endfunction

  function automatic val_t rand_val();
    case ($urandom_range(0, 9))
      0: return val_t'($urandom_range(0, 1) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}});
      1, 2, 3: return val_t'($signed($urandom_range(0, 8000)) - 4000);
      default: return val_t'($urandom);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int span;
    p.apx = rand_val();
    p.apy = rand_val();
    p.avx = rand_val();
    p.avy = rand_val();
    p.bvx = rand_val();
    p.bvy = rand_val();
    if ($urandom_range(0, 3) != 0) begin
      span = int'(contact_dist);
      p.bpx = p.apx + val_t'($signed($urandom_range(0, 2 * span)) - span);
      p.bpy = p.apy + val_t'($signed($urandom_range(0, 2 * span)) - span);
    end else begin
      p.bpx = rand_val();
      p.bpy = rand_val();
    end
    return p;
  endfunction

  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_bounces.push_back(predict_bounce(pending_pairs.pop_front(), contact_dist));
        accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 0;
        end else if (pending_pairs.size() > 0 && !sender_pause) begin
          in_valid <= 1;
          {a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y}
            <= pending_pairs[0];
          if ($urandom_range(0, 3) == 0)
            gap_left = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    bounce_t got, want;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {in_contact, a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y};
        if (expected_bounces.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_bounces.pop_front();
          checked++;
          if (got.contact) contacts++;
          if (got.contact !== want.contact || got.nax !== want.nax || got.nay !== want.nay ||
              got.nbx !== want.nbx || got.nby !== want.nby) begin
            $display("%0t: mismatch expected c=%0b %0d %0d %0d %0d actual c=%0b %0d %0d %0d %0d",
                     $time, want.contact, want.nax, want.nay, want.nbx, want.nby,
                     got.contact, got.nax, got.nay, got.nbx, got.nby);
            errors++;
          end
        end
      end
      if (hold_off_req) begin
        hold_off_req = 0;
        hold_off_left = 200;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_stall <= 1;
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall <= 1;
      end else if ($urandom_range(0, 60) == 0) begin
        hold_off_left = $urandom_range(10, 50);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_bounces.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_contact_dist(logic [CD_WIDTH-1:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    contact_dist = v;
  endtask

  task automatic add_pair(int apx, int apy, int avx, int avy,
                          int bpx, int bpy, int bvx, int bvy);
    pending_pairs.push_back('{val_t'(apx), val_t'(apy), val_t'(avx), val_t'(avy),
                              val_t'(bpx), val_t'(bpy), val_t'(bvx), val_t'(bvy)});
  endtask

  localparam val_t VMAX = {1'b0, {(W-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(W-1){1'b0}}};

  initial begin
    logic [CD_WIDTH-1:0] dists[5];
    dists = '{23'd0, 23'd1, 23'd700, 23'd40000, {CD_WIDTH{1'b1}}};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // default distance, directed cases
    add_pair(0, 0, 256, 0, 1280, 0, -256, 0);
    add_pair(0, 0, 256, 0, 2560, 0, -256, 0);
    add_pair(0, 0, 256, 0, 2561, 0, -256, 0);
    add_pair(100, 100, 5, -7, 100, 100, 9, 3);
    add_pair(0, 0, VMAX, VMAX, 100, 100, VMIN, VMIN);
    add_pair(0, 0, VMIN, VMIN, 100, 100, VMAX, VMAX);
    add_pair(VMAX, VMAX, 0, 0, VMIN, VMIN, 0, 0);
    add_pair(VMIN, 0, 1, 2, VMIN, 1, 3, 4);
    add_pair(0, 0, 300, -50, 1000, 1000, -300, 50);
    add_pair(-1, -1, -1, -1, 0, 0, 0, 0);
    drain();
    write_contact_dist({CD_WIDTH{1'b1}});
    add_pair(VMAX, VMAX, VMAX, VMIN, VMIN, VMIN, VMIN, VMAX);
    add_pair(VMIN, VMAX, VMIN, VMAX, VMAX, VMIN, VMAX, VMIN);
    add_pair(0, 0, VMAX, 0, 1, 0, VMIN, 0);
    add_pair(0, 0, 7, 9, 0, 1, -3, 4);
    drain();
    write_contact_dist(0);
    add_pair(5, 5, 100, 200, 5, 5, 1, 2);
    add_pair(5, 5, 100, 200, 5, 6, 1, 2);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_contact_dist(ph < 5 ? dists[ph] : 23'($urandom_range(1, 20000)));
      for (int i = 0; i < NUM_RANDOM / 7; i++) pending_pairs.push_back(rand_pair());
      if (ph == 2) begin
        hold_off_req = 1;
      end
      if (ph == 4) begin
        while (pending_pairs.size() > 120) @(posedge clk);
        sender_pause = 1;
        while (in_valid || expected_bounces.size() > 0) @(posedge clk);
        sender_pause = 0;
      end
      drain();
    end
    write_contact_dist(CD_RESET);

    $display("covered %0d pairs, %0d results checked, %0d in contact", accepted, checked, contacts);
    $display("contact distances from zero to full scale, with stalls on both sides");
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end
endmodule
